// ===== hdl/viu_pkg.sv =====
package viu_pkg;

  localparam int unsigned RegBitsDef = 128;
  localparam int unsigned NumRegsDef = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgDataW   = 5;

  typedef enum logic [4:0] {
    CMD_ADD_VV    = 5'd0,
    CMD_ADD_VI    = 5'd1,
    CMD_SUB_VV    = 5'd2,
    CMD_RSUB_VI   = 5'd3,
    CMD_AND_VV    = 5'd4,
    CMD_AND_VI    = 5'd5,
    CMD_OR_VV     = 5'd6,
    CMD_OR_VI     = 5'd7,
    CMD_XOR_VV    = 5'd8,
    CMD_XOR_VI    = 5'd9,
    CMD_MV_V      = 5'd10,
    CMD_MV_I      = 5'd11,
    CMD_MIN       = 5'd12,
    CMD_MAX       = 5'd13,
    CMD_MINU      = 5'd14,
    CMD_MAXU      = 5'd15,
    CMD_GATHER_VV = 5'd16,
    CMD_GATHER_VI = 5'd17,
    CMD_GATHER_16 = 5'd18,
    CMD_SLIDEUP   = 5'd19,
    CMD_SLIDEDN   = 5'd20,
    CMD_WRITE     = 5'd21,
    CMD_READ      = 5'd22
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_ELEM_WIDTH = 1'b0,
    CFG_VEC_LEN    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    JOB_VEC,
    JOB_WRITE,
    JOB_READ,
    JOB_NOP
  } job_cls_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_RD_D,
    S_CAP_D,
    S_EXEC,
    S_ONE,
    S_WB,
    S_OUT
  } back_state_e;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [4:0]  imm;
    logic        unmasked;
    logic [5:0]  elem_index;
    logic [63:0] elem_data;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        done_res;
  } out_item_t;

  typedef struct packed {
    logic [1:0] elem_width_code;
    logic [4:0] vector_length;
  } cfg_t;

  typedef struct packed {
    job_cls_e    cls;
    logic [4:0]  cmd;
    logic [4:0]  vd;
    logic [4:0]  vs1;
    logic [4:0]  vs2;
    logic [4:0]  imm;
    logic [5:0]  eidx;
    logic [63:0] edata;
  } job_t;

  function automatic logic [63:0] emask(input logic [1:0] code);
    logic [63:0] m;
    case (code)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/viu_queue.sv =====
module viu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  viu_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output viu_pkg::job_t head_o,
  output logic          empty_o
);
  import viu_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QueueDepth))
    else $error("queue count overflow");

endmodule

// ===== hdl/viu_front.sv =====
module viu_front (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  viu_pkg::in_item_t in_item_i,
  input  logic             q_full_i,
  output logic             push_o,
  output viu_pkg::job_t    job_o
);
  import viu_pkg::*;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    job_o.cmd   = in_item_i.cmd;
    job_o.vd    = in_item_i.dest_reg;
    job_o.vs1   = in_item_i.src1_reg;
    job_o.vs2   = in_item_i.src2_reg;
    job_o.imm   = in_item_i.imm;
    job_o.eidx  = in_item_i.elem_index;
    job_o.edata = in_item_i.elem_data;
    // write/read ignore the mask bit; unused codes retire as no-ops
    if (in_item_i.cmd == CMD_WRITE) begin
      job_o.cls = JOB_WRITE;
    end else if (in_item_i.cmd == CMD_READ) begin
      job_o.cls = JOB_READ;
    end else if (in_item_i.cmd > CMD_READ || !in_item_i.unmasked) begin
      job_o.cls = JOB_NOP;
    end else begin
      job_o.cls = JOB_VEC;
    end
  end

endmodule

// ===== hdl/viu_back.sv =====
module viu_back #(
  parameter int unsigned REG_BITS = viu_pkg::RegBitsDef,
  parameter int unsigned NUM_REGS = viu_pkg::NumRegsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  viu_pkg::cfg_t      cfg_i,
  input  viu_pkg::job_t      head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output viu_pkg::out_item_t out_item_o
);
  import viu_pkg::*;

  localparam int unsigned AddrW   = $clog2(NUM_REGS);
  localparam int unsigned Ei16Max = REG_BITS / 16;

  function automatic logic [63:0] elem_get(input logic [REG_BITS-1:0] r,
                                           input logic [6:0] idx,
                                           input logic [1:0] code);
    logic [12:0]         pos;
    logic [REG_BITS-1:0] sh;
    pos = 13'({idx, 3'b000}) << code;
    sh  = r >> pos;
    return sh[63:0] & emask(code);
  endfunction

  function automatic logic [REG_BITS-1:0] elem_put(input logic [REG_BITS-1:0] r,
                                                   input logic [6:0] idx,
                                                   input logic [1:0] code,
                                                   input logic [63:0] v);
    logic [12:0]         pos;
    logic [REG_BITS-1:0] m;
    logic [REG_BITS-1:0] d;
    pos = 13'({idx, 3'b000}) << code;
    m   = REG_BITS'(emask(code)) << pos;
    d   = REG_BITS'(v & emask(code)) << pos;
    return (r & ~m) | d;
  endfunction

  logic [REG_BITS-1:0] mem_q [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;
  logic [REG_BITS-1:0] rdata_q;
  logic                rvld_q;
  logic [REG_BITS-1:0] rdata;
  logic [AddrW-1:0]    raddr;
  logic                we;

  back_state_e         state_q, state_d;
  job_t                job_q;
  logic [REG_BITS-1:0] a_q, b_q, d_q;
  logic [4:0]          i_q, end_q;
  logic [6:0]          elem_cnt_q;
  logic [63:0]         res_q;
  logic                out_valid_q;
  out_item_t           out_q;
  logic                out_free;

  // configuration derived values
  logic [1:0]  code;
  logic [7:0]  vlmax;
  logic [4:0]  vl;
  logic [63:0] m, sb, simm;

  assign code  = cfg_i.elem_width_code;
  assign vlmax = 8'(REG_BITS >> (32'd3 + 32'(code)));
  assign vl    = ({3'b000, cfg_i.vector_length} > vlmax) ? vlmax[4:0] : cfg_i.vector_length;
  assign m     = emask(code);
  assign sb    = 64'd1 << ((7'd8 << code) - 7'd1);
  assign simm  = (job_q.imm[4] ? {59'h7FF_FFFF_FFFF_FFFF, job_q.imm} : 64'(job_q.imm)) & m;
  assign rdata = rvld_q ? rdata_q : '0;
  assign out_free = !out_valid_q || !out_stall_i;

  // element datapath
  logic [6:0]  i7, src7, dst7;
  logic [63:0] x, y, gidx, gres, r;
  logic        slide;

  always_comb begin
    slide = (job_q.cmd == CMD_SLIDEUP) || (job_q.cmd == CMD_SLIDEDN);
    i7    = 7'(i_q);
    src7  = (job_q.cmd == CMD_SLIDEUP) ? 7'(i_q - job_q.imm) : i7;
    dst7  = (job_q.cmd == CMD_SLIDEDN) ? 7'(i_q - job_q.imm) : i7;
    x     = elem_get(a_q, i7, code);
    y     = elem_get(b_q, src7, code);
    case (job_q.cmd)
      CMD_GATHER_VI: gidx = 64'(job_q.imm);
      CMD_GATHER_16: gidx = elem_get(a_q, i7, 2'd1);
      default:       gidx = x;
    endcase
    gres = (gidx < 64'(vlmax)) ? elem_get(b_q, gidx[6:0], code) : '0;
    case (job_q.cmd)
      CMD_ADD_VV:  r = x + y;
      CMD_ADD_VI:  r = y + simm;
      CMD_SUB_VV:  r = y - x;
      CMD_RSUB_VI: r = simm - y;
      CMD_AND_VV:  r = x & y;
      CMD_AND_VI:  r = y & simm;
      CMD_OR_VV:   r = x | y;
      CMD_OR_VI:   r = y | simm;
      CMD_XOR_VV:  r = x ^ y;
      CMD_XOR_VI:  r = y ^ simm;
      CMD_MV_V:    r = x;
      CMD_MV_I:    r = simm;
      CMD_MIN:     r = ((y ^ sb) > (x ^ sb)) ? x : y;
      CMD_MAX:     r = ((y ^ sb) > (x ^ sb)) ? y : x;
      CMD_MINU:    r = (y > x) ? x : y;
      CMD_MAXU:    r = (y > x) ? y : x;
      CMD_SLIDEUP, CMD_SLIDEDN: r = y;
      default:     r = gres;
    endcase
  end

  // loop bounds, taken when the destination is captured
  logic [4:0] start_c, end_c;
  always_comb begin
    start_c = '0;
    end_c   = vl;
    if (slide) begin
      if (job_q.imm < vl) begin
        start_c = job_q.imm;
      end else begin
        end_c = '0;
      end
    end else if (job_q.cmd == CMD_GATHER_16 && 32'(vl) > Ei16Max) begin
      end_c = 5'(Ei16Max);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          state_d = (head_i.cls == JOB_NOP) ? S_OUT : S_RD_A;
        end
      end
      S_RD_A:  state_d = S_RD_B;
      S_RD_B:  state_d = S_RD_D;
      S_RD_D:  state_d = S_CAP_D;
      S_CAP_D: begin
        if (job_q.cls != JOB_VEC) begin
          state_d = S_ONE;
        end else if (start_c < end_c) begin
          state_d = S_EXEC;
        end else begin
          state_d = S_WB;
        end
      end
      S_EXEC:  state_d = (i_q + 5'd1 == end_q) ? S_WB : S_EXEC;
      S_ONE:   state_d = (job_q.cls == JOB_READ) ? S_OUT : S_WB;
      S_WB:    state_d = S_OUT;
      S_OUT:   state_d = out_free ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o = 1'b0;
    we    = 1'b0;
    raddr = job_q.vs1;
    unique case (state_q)
      S_IDLE:  pop_o = !empty_i;
      S_RD_B:  raddr = job_q.vs2;
      S_RD_D:  raddr = job_q.vd;
      S_WB:    we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      elem_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      rvld_q  <= vld_q[raddr];
      if (we) begin
        vld_q[job_q.vd] <= 1'b1;
      end
      if (state_q == S_CAP_D && job_q.cls == JOB_VEC) begin
        elem_cnt_q <= 7'(end_c - start_c);
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr];
    if (we) begin
      mem_q[job_q.vd] <= d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        job_q <= head_i;
        res_q <= '0;
      end
      S_RD_B:  a_q <= rdata;
      S_RD_D:  b_q <= rdata;
      S_CAP_D: begin
        d_q   <= rdata;
        i_q   <= start_c;
        end_q <= end_c;
      end
      S_EXEC: begin
        d_q <= elem_put(d_q, dst7, code, r);
        i_q <= i_q + 5'd1;
      end
      S_ONE: begin
        if (8'(job_q.eidx) < vlmax) begin
          if (job_q.cls == JOB_WRITE) begin
            d_q <= elem_put(d_q, 7'(job_q.eidx), code, job_q.edata);
          end else begin
            res_q <= elem_get(d_q, 7'(job_q.eidx), code);
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_q.read_data <= res_q;
          out_q.done_res  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> (i_q < end_q))
    else $error("element loop past its end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_cnt_q <= 7'd31)
    else $error("element count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == S_RD_A || state_q == S_OUT))
    else $error("pop did not start a job");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |=> vld_q[job_q.vd])
    else $error("write-back left entry invalid");

endmodule

// ===== hdl/vector_integer_execute_unit.sv =====
// Vector integer execute unit. Each item is one command on a 32-entry file of
// REG_BITS-bit vector registers: add/sub/rsub, and/or/xor, move, min/max,
// register gathers, slides, plus single-element write and read. Every item
// returns exactly one result item (read_data is zero except for element reads,
// done_res is always 1). The front end decodes each item and parks it in a
// two-entry queue; the back end runs one command at a time. A vector command
// takes the item from the queue, reads vs1, vs2 and vd through the single
// register-file read port (one address per cycle, registered data), computes
// the written elements one per cycle (at most the vector length, 0 for a slide
// whose offset is not below it), writes vd back and loads the output register.
// Element write updates one element before the write-back, element read skips
// it, masked or unused commands go from the queue straight to the output
// register. A stalled result holds the back end in its output state until the
// waiting item is taken. The register file reads as zero after reset through
// per-entry valid bits, so no clearing pass is needed. Configuration (element
// width, vector length) may be written only while the unit is idle.
module vector_integer_execute_unit #(
  parameter int unsigned REG_BITS = viu_pkg::RegBitsDef,
  parameter int unsigned NUM_REGS = viu_pkg::NumRegsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  viu_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output viu_pkg::out_item_t           out_item_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [viu_pkg::CfgDataW-1:0] cfg_data_i
);
  import viu_pkg::*;

  cfg_t cfg_q;
  logic q_full, q_empty, push, pop;
  job_t push_job, head_job;

  // config registers; to be written only while idle, which the block does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ELEM_WIDTH: cfg_q.elem_width_code <= cfg_data_i[1:0];
        CFG_VEC_LEN:    cfg_q.vector_length   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  viu_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  viu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head_job),
    .empty_o    (q_empty)
  );

  viu_back #(
    .REG_BITS (REG_BITS),
    .NUM_REGS (NUM_REGS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
